// File: rtl/assert_macros.svh
// Assertion macros included by the packet receiver RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("invariant violated");
`define ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication violated");
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");
`else
`define ASSERT_ALWAYS(lbl, expr)
`define ASSERT_IMPLIES(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/fcpr_pkg.sv
// Shared widths, defaults and control struct of the framed channel packet receiver
package fcpr_pkg;

	localparam int MAX_CHANNELS_DEF = 6;
	localparam int BYTE_W           = 8;
	localparam int GAIN_W           = 8;
	localparam int OFFSET_W         = 16;
	localparam int PULSE_W          = 16;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
		logic mul_en;
	} fcpr_ctl_t;

endpackage

// File: rtl/fcpr_chan_unit.sv
// Channel byte store and shared multiply-add unit
module fcpr_chan_unit #(
	parameter int MAX_CHANNELS = fcpr_pkg::MAX_CHANNELS_DEF,
	parameter int IDX_W        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
	input  logic                          clk,
	input  fcpr_pkg::fcpr_ctl_t           ctl,
	input  logic [IDX_W-1:0]              wr_idx,
	input  logic [fcpr_pkg::BYTE_W-1:0]   wr_data,
	input  logic [IDX_W-1:0]              rd_idx,
	input  logic [fcpr_pkg::GAIN_W-1:0]   gain,
	input  logic [fcpr_pkg::OFFSET_W-1:0] offset,
	output logic [fcpr_pkg::PULSE_W-1:0]  sum
);

	logic [fcpr_pkg::BYTE_W-1:0]  store_q [MAX_CHANNELS];
	logic [fcpr_pkg::BYTE_W-1:0]  rd_q;
	logic [fcpr_pkg::PULSE_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			store_q[wr_idx] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_q <= store_q[rd_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_q <= fcpr_pkg::PULSE_W'(rd_q * gain);
		end
	end

	assign sum = prod_q + offset;

endmodule

// File: rtl/framed_channel_packet_receiver.sv
// Framed channel packet receiver: header hunt, check and per-channel scaling
// A byte with no result leaves the receiver ready for the next byte; one with a status word
// holds off input until the word enters the output register. A good check byte then steps
// each channel through the shared store-read, multiply and add unit; back-pressure stalls it.
// Reset (arst_n low) returns to header hunt with gain 1 and offset 0.
// The channel byte store is not cleared by reset.
`include "assert_macros.svh"

module framed_channel_packet_receiver #(
	parameter int MAX_CHANNELS = fcpr_pkg::MAX_CHANNELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [fcpr_pkg::BYTE_W-1:0]   rx_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    status,
	output logic [2:0]                    channel_index,
	output logic [fcpr_pkg::PULSE_W-1:0]  pulse_value,
	output logic [2:0]                    channel_count,
	output logic                          last,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [fcpr_pkg::OFFSET_W-1:0] cfg_data
);

	localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
	localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	localparam logic [fcpr_pkg::BYTE_W-1:0] HDR_FIRST  = 8'h47;
	localparam logic [fcpr_pkg::BYTE_W-1:0] HDR_SECOND = 8'h4F;
	localparam logic [fcpr_pkg::BYTE_W-1:0] HDR_THIRD  = 8'h00;

	localparam logic [1:0] REG_GAIN   = 2'd0;
	localparam logic [1:0] REG_OFFSET = 2'd1;

	localparam logic [2:0] PS_HUNT  = 3'd0;
	localparam logic [2:0] PS_GOT_G = 3'd1;
	localparam logic [2:0] PS_GOT_O = 3'd2;
	localparam logic [2:0] PS_COUNT = 3'd3;
	localparam logic [2:0] PS_DATA  = 3'd4;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_STATUS = 3'd1;
	localparam logic [2:0] S_READ   = 3'd2;
	localparam logic [2:0] S_MUL    = 3'd3;
	localparam logic [2:0] S_ADD    = 3'd4;

	localparam logic [1:0] ST_UPDATE   = 2'd0;
	localparam logic [1:0] ST_MISMATCH = 2'd1;
	localparam logic [1:0] ST_OVERSIZE = 2'd2;
	localparam logic [1:0] ST_EMPTY    = 2'd3;

	function automatic logic [3:0] ones_in(input logic [7:0] v);
		logic [3:0] n;
		n = 4'd0;
		for (int b = 0; b < 8; b++) begin
			n = n + {3'd0, v[b]};
		end
		return n;
	endfunction

	logic [2:0]                    parse_q;
	logic [2:0]                    seq_q;
	logic [CNT_W-1:0]              count_q;
	logic [CNT_W-1:0]              bidx_q;
	logic [7:0]                    ones_q;
	logic [IDX_W-1:0]              emit_idx_q;
	logic [1:0]                    pend_status_q;
	logic [CNT_W-1:0]              pend_count_q;
	logic [fcpr_pkg::GAIN_W-1:0]   gain_q;
	logic [fcpr_pkg::OFFSET_W-1:0] offset_q;

	logic                          out_valid_q;
	logic [1:0]                    status_q;
	logic [IDX_W-1:0]              chan_q;
	logic [fcpr_pkg::PULSE_W-1:0]  pulse_q;
	logic [CNT_W-1:0]              cnt_q;
	logic                          last_q;

	logic                          in_fire;
	logic                          out_free;
	logic                          data_byte;
	logic                          emit_last;
	logic [3:0]                    byte_ones;
	fcpr_pkg::fcpr_ctl_t           ctl;
	logic [fcpr_pkg::PULSE_W-1:0]  sum;

	assign in_ready  = (seq_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;
	assign byte_ones = ones_in(rx_byte);
	assign data_byte = (parse_q == PS_DATA) && (bidx_q < count_q);
	assign emit_last = (CNT_W'(emit_idx_q) == (count_q - CNT_W'(1)));

	always_comb begin
		ctl.wr_en  = in_fire && data_byte;
		ctl.rd_en  = (seq_q == S_READ);
		ctl.mul_en = (seq_q == S_MUL);
	end

	fcpr_chan_unit #(
		.MAX_CHANNELS (MAX_CHANNELS),
		.IDX_W        (IDX_W)
	) u_chan (
		.clk     (clk),
		.ctl     (ctl),
		.wr_idx  (bidx_q[IDX_W-1:0]),
		.wr_data (rx_byte),
		.rd_idx  (emit_idx_q),
		.gain    (gain_q),
		.offset  (offset_q),
		.sum     (sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= fcpr_pkg::GAIN_W'(1);
			offset_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GAIN:   gain_q   <= cfg_data[fcpr_pkg::GAIN_W-1:0];
				REG_OFFSET: offset_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_q       <= PS_HUNT;
			seq_q         <= S_IDLE;
			count_q       <= '0;
			bidx_q        <= '0;
			ones_q        <= '0;
			emit_idx_q    <= '0;
			pend_status_q <= ST_UPDATE;
			pend_count_q  <= '0;
		end else begin
			case (seq_q)
				S_IDLE: begin
					if (in_fire) begin
						case (parse_q)
							PS_HUNT: begin
								if (rx_byte == HDR_FIRST) begin
									parse_q <= PS_GOT_G;
								end
							end
							PS_GOT_G: parse_q <= (rx_byte == HDR_SECOND) ? PS_GOT_O : PS_HUNT;
							PS_GOT_O: parse_q <= (rx_byte == HDR_THIRD) ? PS_COUNT : PS_HUNT;
							PS_COUNT: begin
								if (rx_byte > fcpr_pkg::BYTE_W'(MAX_CHANNELS)) begin
									pend_status_q <= ST_OVERSIZE;
									pend_count_q  <= '0;
									seq_q         <= S_STATUS;
									parse_q       <= PS_HUNT;
								end else begin
									count_q <= rx_byte[CNT_W-1:0];
									bidx_q  <= '0;
									ones_q  <= 8'(byte_ones);
									parse_q <= PS_DATA;
								end
							end
							PS_DATA: begin
								if (data_byte) begin
									ones_q <= ones_q + 8'(byte_ones);
									bidx_q <= bidx_q + CNT_W'(1);
								end else begin
									if (rx_byte != ones_q) begin
										pend_status_q <= ST_MISMATCH;
										pend_count_q  <= count_q;
										seq_q         <= S_STATUS;
									end else if (count_q == '0) begin
										pend_status_q <= ST_EMPTY;
										pend_count_q  <= '0;
										seq_q         <= S_STATUS;
									end else begin
										emit_idx_q <= '0;
										seq_q      <= S_READ;
									end
									parse_q <= PS_HUNT;
								end
							end
							default: parse_q <= PS_HUNT;
						endcase
					end
				end
				S_STATUS: begin
					if (out_free) begin
						seq_q <= S_IDLE;
					end
				end
				S_READ: seq_q <= S_MUL;
				S_MUL:  seq_q <= S_ADD;
				S_ADD: begin
					if (out_free) begin
						if (emit_last) begin
							seq_q <= S_IDLE;
						end else begin
							emit_idx_q <= emit_idx_q + IDX_W'(1);
							seq_q      <= S_READ;
						end
					end
				end
				default: seq_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= (seq_q == S_STATUS) || (seq_q == S_ADD);
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && seq_q == S_STATUS) begin
			status_q <= pend_status_q;
			chan_q   <= '0;
			pulse_q  <= '0;
			cnt_q    <= pend_count_q;
			last_q   <= 1'b1;
		end else if (out_free && seq_q == S_ADD) begin
			status_q <= ST_UPDATE;
			chan_q   <= emit_idx_q;
			pulse_q  <= sum;
			cnt_q    <= count_q;
			last_q   <= emit_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign channel_index = 3'(chan_q);
	assign pulse_value   = pulse_q;
	assign channel_count = 3'(cnt_q);
	assign last          = last_q;

	`ASSERT_IMPLIES(a_busy_hunts, seq_q != S_IDLE, parse_q == PS_HUNT)
	`ASSERT_IMPLIES(a_emit_in_range, (seq_q == S_READ) || (seq_q == S_MUL) || (seq_q == S_ADD), CNT_W'(emit_idx_q) < count_q)
	`ASSERT_IMPLIES(a_fill_bound, parse_q == PS_DATA, bidx_q <= count_q)
	`ASSERT_NEXT(a_last_word, (seq_q == S_ADD) && out_free && emit_last, (seq_q == S_IDLE) && out_valid_q && last_q)

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the framed channel packet receiver: scoreboard and framed traffic
module testbench;

	localparam int MAX_CH = fcpr_pkg::MAX_CHANNELS_DEF;
	localparam bit [7:0] HDR_G = 8'h47;
	localparam bit [7:0] HDR_O = 8'h4F;
	localparam bit [7:0] HDR_Z = 8'h00;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES = 300;

	typedef enum bit [2:0] {PS_HUNT, PS_GOT_G, PS_GOT_O, PS_COUNT, PS_DATA} parse_t;
	typedef enum bit [1:0] {ST_UPDATE, ST_MISMATCH, ST_OVERSIZE, ST_EMPTY} status_t;
	typedef enum bit [1:0] {REG_GAIN, REG_OFFSET, REG_SPARE_A, REG_SPARE_B} reg_idx_t;

	typedef struct packed {
		status_t     st;
		bit [2:0]    ch;
		bit [15:0]   pv;
		bit [2:0]    cnt;
		bit          lst;
	} chan_word_t;

	class channel_update_board;
		bit [fcpr_pkg::GAIN_W-1:0]   gain;
		bit [fcpr_pkg::OFFSET_W-1:0] offset;
		parse_t                      pstate;
		bit [2:0]                    frame_cnt;
		bit [2:0]                    idx;
		bit [7:0]                    ones;
		bit [7:0]                    store[MAX_CH];
		chan_word_t                  due_words[$];
		int                          errors;

		function new();
			gain = 1;
			offset = 0;
			pstate = PS_HUNT;
			frame_cnt = 0;
			idx = 0;
			ones = 0;
			errors = 0;
		endfunction

		function void write_reg(reg_idx_t ri, bit [15:0] data);
			if (ri == REG_GAIN)
				gain = data[7:0];
			else if (ri == REG_OFFSET)
				offset = data;
		endfunction

		function void due(status_t st, bit [2:0] ch, bit [15:0] pv, bit [2:0] cnt, bit lst);
			chan_word_t w;
			w.st = st;
			w.ch = ch;
			w.pv = pv;
			w.cnt = cnt;
			w.lst = lst;
			due_words.push_back(w);
		endfunction

		function void take_byte(bit [7:0] b);
			int unsigned v;
			case (pstate)
				PS_HUNT: begin
					if (b == HDR_G)
						pstate = PS_GOT_G;
				end
				PS_GOT_G: pstate = (b == HDR_O) ? PS_GOT_O : PS_HUNT;
				PS_GOT_O: pstate = (b == HDR_Z) ? PS_COUNT : PS_HUNT;
				PS_COUNT: begin
					if (b > MAX_CH) begin
						due(ST_OVERSIZE, 0, 0, 0, 1);
						pstate = PS_HUNT;
					end else begin
						frame_cnt = b[2:0];
						idx = 0;
						ones = 8'($countones(b));
						pstate = PS_DATA;
					end
				end
				PS_DATA: begin
					if (idx < frame_cnt) begin
						store[idx] = b;
						ones = ones + 8'($countones(b));
						idx++;
					end else begin
						if (b != ones)
							due(ST_MISMATCH, 0, 0, frame_cnt, 1);
						else if (frame_cnt == 0)
							due(ST_EMPTY, 0, 0, 0, 1);
						else begin
							for (int i = 0; i < frame_cnt; i++) begin
								v = store[i] * gain + offset;
								due(ST_UPDATE, 3'(i), v[15:0], frame_cnt, i == frame_cnt - 1);
							end
						end
						pstate = PS_HUNT;
					end
				end
				default: pstate = PS_HUNT;
			endcase
		endfunction

		function void compare(string field, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", field, want, got);
				errors++;
			end
		endfunction

		function void match_word(logic [1:0] st, logic [2:0] ch, logic [15:0] pv,
				logic [2:0] cnt, logic lst);
			chan_word_t w;
			if (due_words.size() == 0) begin
				$error("word with nothing due: status %0d channel %0d value %0d", st, ch, pv);
				errors++;
				return;
			end
			w = due_words.pop_front();
			compare("status", w.st, st);
			compare("channel_index", w.ch, ch);
			compare("pulse_value", w.pv, pv);
			compare("channel_count", w.cnt, cnt);
			compare("last", w.lst, lst);
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic [fcpr_pkg::BYTE_W-1:0]   rx_byte = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [1:0]                    status;
	logic [2:0]                    channel_index;
	logic [fcpr_pkg::PULSE_W-1:0]  pulse_value;
	logic [2:0]                    channel_count;
	logic                          last;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [1:0]                    cfg_index = '0;
	logic [fcpr_pkg::OFFSET_W-1:0] cfg_data = '0;

	channel_update_board sb = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_reqs = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int bytes_sent = 0;

	framed_channel_packet_receiver dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.channel_index (channel_index),
		.pulse_value   (pulse_value),
		.channel_count (channel_count),
		.last          (last),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (hold_seen != hold_reqs) begin
			hold_seen <= hold_reqs;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else
			out_ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.match_word(status, channel_index, pulse_value, channel_count, last);
	end

	task automatic send_byte(input bit [7:0] b);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		sb.take_byte(b);
		bytes_sent++;
	endtask

	task automatic write_reg(input reg_idx_t ri, input bit [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= ri;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(ri, data);
	endtask

	task automatic end_writes();
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// drive the parser back to hunting, then drain every word due
	task automatic settle();
		while (sb.pstate != PS_HUNT)
			send_byte(8'h00);
		in_valid <= 1'b0;
		while (sb.due_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_frame(input bit [7:0] cnt_byte, input bit bad_check);
		bit [7:0] ones;
		bit [7:0] d;
		send_byte(HDR_G);
		send_byte(HDR_O);
		send_byte(HDR_Z);
		send_byte(cnt_byte);
		if (cnt_byte > MAX_CH)
			return;
		ones = 8'($countones(cnt_byte));
		for (int i = 0; i < cnt_byte; i++) begin
			d = 8'($urandom);
			ones = ones + 8'($countones(d));
			send_byte(d);
		end
		if (bad_check)
			ones = ones ^ 8'($urandom_range(255, 1));
		send_byte(ones);
	endtask

	task automatic broken_sequence();
		int pick;
		bit [7:0] b;
		pick = $urandom_range(2);
		send_byte(HDR_G);
		if (pick == 0) begin
			b = 8'($urandom);
			if (b == HDR_O)
				b = HDR_G;
			send_byte(b);
		end else if (pick == 1) begin
			send_byte(HDR_O);
			send_byte(8'($urandom_range(255, 1)));
		end else begin
			// truncate: the next frame's bytes land in the data slots
			send_byte(HDR_O);
			send_byte(HDR_Z);
			send_byte(8'($urandom_range(MAX_CH, 2)));
			send_byte(8'($urandom));
		end
	endtask

	task automatic run_random(input int target);
		int start;
		int kind;
		int k;
		start = bytes_sent;
		while (bytes_sent - start < target) begin
			kind = $urandom_range(99);
			if (kind < 60)
				send_frame(8'($urandom_range(MAX_CH, 1)), 1'b0);
			else if (kind < 68)
				send_frame(8'h00, 1'b0);
			else if (kind < 80)
				send_frame(8'($urandom_range(MAX_CH)), 1'b1);
			else if (kind < 88)
				send_frame(8'($urandom_range(255, MAX_CH + 1)), 1'b0);
			else if (kind < 94)
				broken_sequence();
			else begin
				k = $urandom_range(3, 1);
				repeat (k) send_byte(8'($urandom));
			end
		end
	endtask

	initial begin
		bit [7:0] opening[$];
		opening = '{
			HDR_G, HDR_O, 8'h01,
			HDR_G, HDR_G,
			HDR_G, HDR_O, HDR_Z, 8'h00, 8'h00,
			HDR_G, HDR_O, HDR_Z, 8'hFF,
			HDR_G, HDR_O, HDR_Z, 8'h01, 8'hFF, 8'h09,
			HDR_G, HDR_O, HDR_Z, 8'h00, 8'h05
		};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 33;
		recv_stall_pct <= 53;
		write_reg(REG_GAIN, 16'h00FF);
		write_reg(REG_OFFSET, 16'hFFFF);
		write_reg(REG_SPARE_A, 16'($urandom));
		end_writes();
		foreach (opening[i])
			send_byte(opening[i]);
		settle();

		write_reg(REG_GAIN, 16'h0000);
		write_reg(REG_OFFSET, 16'h0000);
		end_writes();
		run_random(40);
		settle();

		send_idle_pct = 53;
		recv_stall_pct <= 33;
		write_reg(REG_GAIN, 16'($urandom));
		write_reg(REG_OFFSET, 16'($urandom));
		write_reg(REG_SPARE_B, 16'($urandom));
		end_writes();
		run_random(40);
		settle();

		send_idle_pct = 0;
		recv_stall_pct <= 0;
		write_reg(REG_GAIN, 16'h00FF);
		write_reg(REG_OFFSET, 16'($urandom));
		end_writes();
		hold_reqs <= hold_reqs + 1;
		run_random(30);
		settle();
		run_random(30);
		settle();

		if (sb.errors == 0 && sb.due_words.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	initial begin
		#400000;
		$display("testbench: errors");
		$finish;
	end
endmodule
